>>> rtl/angle_spike_reject_lowpass_defines.svh
// ----------------------------------------------------------------------------
// angle_spike_reject_lowpass_defines
// Assertion macros shared by the angle filter RTL.
// ----------------------------------------------------------------------------
`ifndef ANGLE_SPIKE_REJECT_LOWPASS_DEFINES_SVH
`define ANGLE_SPIKE_REJECT_LOWPASS_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asrl assertion failed");
`define ASRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asrl assertion failed");
`else
`define ASRL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASRL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/asrl_pkg.sv
// ----------------------------------------------------------------------------
// asrl_pkg
// Widths, register map and shared types of the angle spike-reject filter.
// ----------------------------------------------------------------------------
package asrl_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int TOTAL_BITS = ANGLE_BITS + FRAC_BITS;
  localparam int DIFF_BITS  = TOTAL_BITS + 2;
  localparam int GAIN_BITS  = 9;
  localparam int GAIN_FRAC  = 8;
  localparam int LIM_BITS   = 12;
  localparam int PROD_BITS  = GAIN_BITS + 1 + DIFF_BITS;
  localparam int CMP_BITS   = (DIFF_BITS > LIM_BITS + FRAC_BITS) ? DIFF_BITS
                                                                 : LIM_BITS + FRAC_BITS;
  localparam int NUM_LANES  = 3;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  localparam logic signed [DIFF_BITS-1:0] HALF_TURN = DIFF_BITS'(1) << (TOTAL_BITS - 1);
  localparam logic signed [DIFF_BITS-1:0] FULL_TURN = DIFF_BITS'(1) << TOTAL_BITS;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;

  localparam logic [2:0] REG_ALPHA_NORMAL = 3'd0;
  localparam logic [2:0] REG_ALPHA_STRONG = 3'd1;
  localparam logic [2:0] REG_LIM_NORMAL   = 3'd2;
  localparam logic [2:0] REG_LIM_FORCE    = 3'd3;
  localparam logic [2:0] REG_LIM_GUARD    = 3'd4;

  localparam logic [GAIN_BITS-1:0] RST_ALPHA_NORMAL = 9'd102;
  localparam logic [GAIN_BITS-1:0] RST_ALPHA_STRONG = 9'd26;
  localparam logic [LIM_BITS-1:0]  RST_LIM_NORMAL   = 12'd341;
  localparam logic [LIM_BITS-1:0]  RST_LIM_FORCE    = 12'd114;
  localparam logic [LIM_BITS-1:0]  RST_LIM_GUARD    = 12'd34;

  typedef struct packed {
    logic [GAIN_BITS-1:0] alpha_normal;
    logic [GAIN_BITS-1:0] alpha_strong;
    logic [LIM_BITS-1:0]  lim_normal;
    logic [LIM_BITS-1:0]  lim_force;
    logic [LIM_BITS-1:0]  lim_guard;
  } cfg_t;

  typedef struct packed {
    logic                 load;
    logic                 init;
    logic [GAIN_BITS-1:0] gain;
    logic [LIM_BITS-1:0]  limit;
  } lane_ctl_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] angle;
    logic                  taken;
  } lane_res_t;

endpackage

>>> rtl/asrl_cfg.sv
// ----------------------------------------------------------------------------
// asrl_cfg
// APB register file holding filter gains and jump limits.
// ----------------------------------------------------------------------------
module asrl_cfg
  import asrl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_normal <= RST_ALPHA_NORMAL;
      cfg_q.alpha_strong <= RST_ALPHA_STRONG;
      cfg_q.lim_normal   <= RST_LIM_NORMAL;
      cfg_q.lim_force    <= RST_LIM_FORCE;
      cfg_q.lim_guard    <= RST_LIM_GUARD;
    end else if (wr_en) begin
      case (idx)
        REG_ALPHA_NORMAL: cfg_q.alpha_normal <= pwdata[GAIN_BITS-1:0];
        REG_ALPHA_STRONG: cfg_q.alpha_strong <= pwdata[GAIN_BITS-1:0];
        REG_LIM_NORMAL:   cfg_q.lim_normal   <= pwdata[LIM_BITS-1:0];
        REG_LIM_FORCE:    cfg_q.lim_force    <= pwdata[LIM_BITS-1:0];
        REG_LIM_GUARD:    cfg_q.lim_guard    <= pwdata[LIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ALPHA_NORMAL: prdata = DATA_BITS'(cfg_q.alpha_normal);
      REG_ALPHA_STRONG: prdata = DATA_BITS'(cfg_q.alpha_strong);
      REG_LIM_NORMAL:   prdata = DATA_BITS'(cfg_q.lim_normal);
      REG_LIM_FORCE:    prdata = DATA_BITS'(cfg_q.lim_force);
      REG_LIM_GUARD:    prdata = DATA_BITS'(cfg_q.lim_guard);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> rtl/asrl_lane.sv
// ----------------------------------------------------------------------------
// asrl_lane
// One angle channel: wrapped difference, spike check, Q8 gain step, state.
// ----------------------------------------------------------------------------
module asrl_lane
  import asrl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lane_ctl_t             ctl_i,
  input  logic [ANGLE_BITS-1:0] raw_i,
  input  logic                  valid_i,
  output lane_res_t             res_o
);

  logic [TOTAL_BITS-1:0]       angle_q, angle_d;
  logic [TOTAL_BITS-1:0]       reading;
  logic signed [DIFF_BITS-1:0] d_raw, d_wrap;
  logic [DIFF_BITS-1:0]        mag;
  logic [CMP_BITS-1:0]         mag_ext, lim_ext;
  logic signed [PROD_BITS-1:0] prod, corr;
  logic                        taken;

  assign reading = {raw_i, {FRAC_BITS{1'b0}}};
  assign d_raw   = $signed(DIFF_BITS'(reading)) - $signed(DIFF_BITS'(angle_q));

  always_comb begin
    d_wrap = d_raw;
    if (d_raw > HALF_TURN) begin
      d_wrap = d_raw - FULL_TURN;
    end else if (d_raw < -HALF_TURN) begin
      d_wrap = d_raw + FULL_TURN;
    end
  end

  assign mag     = d_wrap[DIFF_BITS-1] ? DIFF_BITS'(-d_wrap) : DIFF_BITS'(d_wrap);
  assign mag_ext = CMP_BITS'(mag);
  assign lim_ext = CMP_BITS'({ctl_i.limit, {FRAC_BITS{1'b0}}});
  assign prod    = $signed({1'b0, ctl_i.gain}) * d_wrap;
  // arithmetic shift gives floor division
  assign corr    = prod >>> GAIN_FRAC;

  always_comb begin
    angle_d = angle_q;
    taken   = 1'b0;
    if (valid_i) begin
      if (!ctl_i.init) begin
        angle_d = reading;
        taken   = 1'b1;
      end else if (mag_ext <= lim_ext) begin
        angle_d = angle_q + corr[TOTAL_BITS-1:0];
        taken   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else if (ctl_i.load) begin
      angle_q <= angle_d;
    end
  end

  assign res_o.angle = angle_d;
  assign res_o.taken = taken;

endmodule

>>> rtl/asrl_out.sv
// ----------------------------------------------------------------------------
// asrl_out
// Registers the lane results and holds them for the consumer.
// ----------------------------------------------------------------------------
module asrl_out
  import asrl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  lane_res_t [NUM_LANES-1:0] res_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  in_ready_o,
  output lane_res_t [NUM_LANES-1:0] res_o
);

  logic                      valid_q;
  lane_res_t [NUM_LANES-1:0] res_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> rtl/angle_spike_reject_lowpass.sv
// ----------------------------------------------------------------------------
// angle_spike_reject_lowpass
// Circular low-pass filter with spike rejection for pitch, yaw and roll.
//
//   channel  direction  handshake                 payload
//   in       in         in_valid_i / in_ready_o   3 x raw + valid, guarding, force
//   out      out        out_valid_o / out_ready_i 3 x filtered + taken
//   cfg      in         APB psel/penable/pready   5 registers at 4*i
//
// One request per cycle while in_ready_o is high; the result is registered and appears in the cycle after acceptance.
// Each lane updates its state in the accepting cycle (wrap, compare, multiply).
// in_ready_o stays high while the output register is empty or being drained.
// Reset clears filter state, the first-item flag and the output valid flag; the held result data is not reset.
// ----------------------------------------------------------------------------
`include "angle_spike_reject_lowpass_defines.svh"

module angle_spike_reject_lowpass
  import asrl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ANGLE_BITS-1:0] pitch_raw_i,
  input  logic                  pitch_valid_i,
  input  logic [ANGLE_BITS-1:0] yaw_raw_i,
  input  logic                  yaw_valid_i,
  input  logic [ANGLE_BITS-1:0] roll_raw_i,
  input  logic                  roll_valid_i,
  input  logic                  guarding_i,
  input  logic                  force_active_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TOTAL_BITS-1:0] pitch_filtered_o,
  output logic [TOTAL_BITS-1:0] yaw_filtered_o,
  output logic [TOTAL_BITS-1:0] roll_filtered_o,
  output logic                  pitch_taken_o,
  output logic                  yaw_taken_o,
  output logic                  roll_taken_o
);

  cfg_t                          cfg;
  lane_ctl_t                     ctl;
  lane_res_t [NUM_LANES-1:0]     lane_res, out_res;
  logic [NUM_LANES-1:0][ANGLE_BITS-1:0] raw;
  logic [NUM_LANES-1:0]          rvalid;
  logic [GAIN_BITS-1:0]          gain_sel;
  logic                          accept;
  logic                          init_q;

  asrl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign accept   = in_valid_i & in_ready_o;
  assign gain_sel = (guarding_i | force_active_i) ? cfg.alpha_strong : cfg.alpha_normal;

  assign ctl.load  = accept;
  assign ctl.init  = init_q;
  assign ctl.gain  = (gain_sel > GAIN_ONE) ? GAIN_ONE : gain_sel;
  assign ctl.limit = guarding_i     ? cfg.lim_guard :
                     force_active_i ? cfg.lim_force : cfg.lim_normal;

  assign raw    = {roll_raw_i, yaw_raw_i, pitch_raw_i};
  assign rvalid = {roll_valid_i, yaw_valid_i, pitch_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
    end else if (accept) begin
      init_q <= 1'b1;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    asrl_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .raw_i   (raw[g]),
      .valid_i (rvalid[g]),
      .res_o   (lane_res[g])
    );
  end

  asrl_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (lane_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .in_ready_o  (in_ready_o),
    .res_o       (out_res)
  );

  assign pitch_filtered_o = out_res[0].angle;
  assign yaw_filtered_o   = out_res[1].angle;
  assign roll_filtered_o  = out_res[2].angle;
  assign pitch_taken_o    = out_res[0].taken;
  assign yaw_taken_o      = out_res[1].taken;
  assign roll_taken_o     = out_res[2].taken;

  `ASRL_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, accept, out_valid_o)
  `ASRL_ASSERT_NEXT(a_pitch_invalid_not_taken, clk_i, rst_ni, accept && !pitch_valid_i,
                    !pitch_taken_o)
  `ASRL_ASSERT_NEXT(a_first_item_loads, clk_i, rst_ni,
                    accept && !init_q && yaw_valid_i,
                    yaw_taken_o && (yaw_filtered_o == {$past(yaw_raw_i), {FRAC_BITS{1'b0}}}))
  `ASRL_ASSERT_NEXT(a_init_sticks, clk_i, rst_ni, init_q, init_q)

endmodule
